// ----- design/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver: beat payloads,
// internal sideband records, fixed-point widths and result kind codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Fixed-point format of coefficients and roots
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_BITS  = 16;
    localparam int KIND_W    = 3;

    // Discriminant and square root widths
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int DISC_W = PROD_W + 3;
    localparam int SQ_X_W = PROD_W + 1;
    localparam int SQ_Y_W = WORD_BITS;
    localparam int ROOT_W = WORD_BITS + 1;
    localparam int SQ_T_W = SQ_X_W + ROOT_W + 1;
    localparam int SQ_LAT = ROOT_W;

    // Divider widths
    localparam int NUM_W   = WORD_BITS + 4;
    localparam int DEN_W   = WORD_BITS + 2;
    localparam int NMAG_W  = NUM_W - 1 + FRAC_BITS;
    localparam int DMAG_W  = DEN_W - 1;
    localparam int QUO_W   = WORD_BITS;
    localparam int REM_W   = DMAG_W + QUO_W;
    localparam int DIV_LAT = QUO_W + 2;

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ONE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TWO   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ANY   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    // How the roots of an item are formed at the output stage
    typedef enum logic [2:0] {
        OP_CONST,
        OP_R1,
        OP_R2,
        OP_BOTH,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] coeff_a;
        logic signed [WORD_BITS-1:0] coeff_b;
        logic signed [WORD_BITS-1:0] coeff_c;
        logic                        coeffs_valid;
    } coeffs_t;

    typedef struct packed {
        logic [KIND_W-1:0]           root_kind;
        logic signed [WORD_BITS-1:0] root_one;
        logic signed [WORD_BITS-1:0] root_two;
        logic                        saturated;
    } roots_t;

    // Divider result: quotient magnitude plus sign and corner flags
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             num_neg;
        logic             den_neg;
        logic             den_zero;
        logic             num_zero;
    } div_res_t;

endpackage

// ----- design/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined scaled integer square root: root = floor(sqrt(x / y)), one root
// bit per stage. With y = 1 this is a plain isqrt. Uses shifts and adds only.
// ----------------------------------------------------------------------------
module qrs_sqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [qrs_pkg::SQ_X_W-1:0]     x,
    input  logic [qrs_pkg::SQ_Y_W-1:0]     y,
    output logic [qrs_pkg::ROOT_W-1:0]     root
);

    localparam int XW = qrs_pkg::SQ_X_W;
    localparam int YW = qrs_pkg::SQ_Y_W;
    localparam int RW = qrs_pkg::ROOT_W;
    localparam int TW = qrs_pkg::SQ_T_W;

    // rem = x - y*r^2, p = y*r
    logic [XW-1:0] rem_reg [RW];
    logic [XW-1:0] p_reg   [RW];
    logic [YW-1:0] y_reg   [RW];
    logic [RW-1:0] r_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [XW-1:0] rem_i;
        logic [XW-1:0] p_i;
        logic [YW-1:0] y_i;
        logic [RW-1:0] r_i;
        logic [TW-1:0] term;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_i = x;
            assign p_i   = '0;
            assign y_i   = y;
            assign r_i   = '0;
        end else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign p_i   = p_reg[k-1];
            assign y_i   = y_reg[k-1];
            assign r_i   = r_reg[k-1];
        end

        // y*(r+2^B)^2 - y*r^2 = p*2^(B+1) + y*2^(2B)
        assign term = (TW'(p_i) << (B + 1)) + (TW'(y_i) << (2 * B));
        assign take = (term <= TW'(rem_i));

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? (rem_i - term[XW-1:0]) : rem_i;
                p_reg[k]   <= take ? (p_i + (XW'(y_i) << B)) : p_i;
                y_reg[k]   <= y_i;
                r_reg[k]   <= take ? (r_i | (RW'(1) << B)) : r_i;
            end
        end
    end

    assign root = r_reg[RW-1];

endmodule

// ----- design/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined signed divider for (num << FRAC_BITS) / den: magnitude stage,
// overflow check stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qrs_pkg::NUM_W-1:0]    num,
    input  logic signed [qrs_pkg::DEN_W-1:0]    den,
    output qrs_pkg::div_res_t                   res
);

    localparam int NW  = qrs_pkg::NUM_W;
    localparam int DW  = qrs_pkg::DEN_W;
    localparam int NMW = qrs_pkg::NMAG_W;
    localparam int DMW = qrs_pkg::DMAG_W;
    localparam int QW  = qrs_pkg::QUO_W;
    localparam int RMW = qrs_pkg::REM_W;
    localparam int FB  = qrs_pkg::FRAC_BITS;

    logic [NW-1:0]      nabs;
    logic [DW-1:0]      dabs;

    // Magnitude stage
    logic [NMW-1:0]     nsh_reg;
    logic [DMW-1:0]     dmag_m_reg;
    qrs_pkg::div_res_t  flag_m_reg;

    // Overflow stage
    logic [RMW-1:0]     rem_o_reg;
    logic [DMW-1:0]     dmag_o_reg;
    qrs_pkg::div_res_t  flag_o_reg;
    qrs_pkg::div_res_t  flag_o_next;

    // Quotient bit stages
    logic [RMW-1:0]     rem_reg  [QW];
    logic [DMW-1:0]     dmag_reg [QW];
    qrs_pkg::div_res_t  res_reg  [QW];

    assign nabs = num[NW-1] ? -num : num;
    assign dabs = den[DW-1] ? -den : den;

    always_ff @(posedge aclk) begin
        if (en) begin
            nsh_reg             <= {nabs[NW-2:0], {FB{1'b0}}};
            dmag_m_reg          <= dabs[DW-2:0];
            flag_m_reg.quo      <= '0;
            flag_m_reg.ovf      <= 1'b0;
            flag_m_reg.num_neg  <= num[NW-1];
            flag_m_reg.den_neg  <= den[DW-1];
            flag_m_reg.den_zero <= (den == '0);
            flag_m_reg.num_zero <= (num == '0);
        end
    end

    // Quotient needs more than QW bits: flag and saturate later
    always_comb begin
        flag_o_next     = flag_m_reg;
        flag_o_next.ovf = (RMW'(nsh_reg) >= {dmag_m_reg, {QW{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_o_reg  <= RMW'(nsh_reg);
            dmag_o_reg <= dmag_m_reg;
            flag_o_reg <= flag_o_next;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic [RMW-1:0]    rem_i;
        logic [DMW-1:0]    dmag_i;
        qrs_pkg::div_res_t res_i;
        qrs_pkg::div_res_t res_n;
        logic [RMW-1:0]    sub;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_i  = rem_o_reg;
            assign dmag_i = dmag_o_reg;
            assign res_i  = flag_o_reg;
        end else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign dmag_i = dmag_reg[k-1];
            assign res_i  = res_reg[k-1];
        end

        assign sub  = RMW'(dmag_i) << B;
        assign take = (rem_i >= sub);

        always_comb begin
            res_n     = res_i;
            res_n.quo = take ? (res_i.quo | (QW'(1) << B)) : res_i.quo;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? (rem_i - sub) : rem_i;
                dmag_reg[k] <= dmag_i;
                res_reg[k]  <= res_n;
            end
        end
    end

    assign res = res_reg[QW-1];

endmodule

// ----- design/quadratic_root_solver_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Throughput: one beat per cycle; set by the 33-stage square root and the
// 34-stage dividers, all fully pipelined and stalled together by m_ready.
// Reset: synchronous active-low aresetn clears all valid bits and the input
// skid slot, and sets tol_reg to 1.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  qrs_pkg::coeffs_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output qrs_pkg::roots_t                     m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qrs_pkg::TOL_BITS-1:0]        cfg_data
);

    localparam int W     = qrs_pkg::WORD_BITS;
    localparam int FB    = qrs_pkg::FRAC_BITS;
    localparam int TB    = qrs_pkg::TOL_BITS;
    localparam int PW    = qrs_pkg::PROD_W;
    localparam int DSW   = qrs_pkg::DISC_W;
    localparam int XW    = qrs_pkg::SQ_X_W;
    localparam int YW    = qrs_pkg::SQ_Y_W;
    localparam int RW    = qrs_pkg::ROOT_W;
    localparam int NW    = qrs_pkg::NUM_W;
    localparam int DW    = qrs_pkg::DEN_W;
    localparam int SLAT  = qrs_pkg::SQ_LAT;
    localparam int DLAT  = qrs_pkg::DIV_LAT;

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic                cv;
        logic                za;
        logic                zb;
        logic                zc;
        logic [W-1:0]        amag;
        logic [W-1:0]        cmag;
    } coef_info_t;

    typedef struct packed {
        qrs_pkg::op_t                  op;
        logic [qrs_pkg::KIND_W-1:0]    kind;
        logic signed [NW-1:0]          n1b;
        logic signed [NW-1:0]          n2b;
        logic                          add_s;
        logic                          sub_s;
        logic signed [DW-1:0]          den1;
        logic signed [DW-1:0]          den2;
    } cls_t;

    typedef struct packed {
        qrs_pkg::op_t                  op;
        logic [qrs_pkg::KIND_W-1:0]    kind;
        logic [RW-1:0]                 root;
    } tail_t;

    typedef struct packed {
        logic signed [W-1:0] val;
        logic                clip;
    } satv_t;

    // Saturate a divider result to the word range
    function automatic satv_t sat_div(input qrs_pkg::div_res_t r);
        satv_t o;
        logic  neg;
        neg    = r.num_neg ^ r.den_neg;
        o.val  = '0;
        o.clip = 1'b0;
        if (r.den_zero) begin
            o.clip = 1'b1;
            if (r.num_zero) begin
                o.val = '0;
            end else if (r.num_neg) begin
                o.val = qrs_pkg::WMIN;
            end else begin
                o.val = qrs_pkg::WMAX;
            end
        end else if (!neg) begin
            if (r.ovf || r.quo[W-1]) begin
                o.val  = qrs_pkg::WMAX;
                o.clip = 1'b1;
            end else begin
                o.val = $signed(r.quo);
            end
        end else begin
            if (r.ovf || (r.quo[W-1] && (|r.quo[W-2:0]))) begin
                o.val  = qrs_pkg::WMIN;
                o.clip = 1'b1;
            end else begin
                o.val = -$signed(r.quo);
            end
        end
        return o;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    logic                       pipe_en;
    logic                       s_acc;
    logic [TB-1:0]              tol_reg;

    logic                       skid_full_reg;
    qrs_pkg::coeffs_t           skid_reg;
    logic                       v0_reg;
    qrs_pkg::coeffs_t           in0_reg;

    logic                       v1_reg;
    coef_info_t                 st1_reg;
    coef_info_t                 st1_next;
    logic signed [PW-1:0]       bb_reg;
    logic signed [PW-1:0]       ac_reg;

    logic                       v2_reg;
    coef_info_t                 st2_reg;
    logic signed [DSW-1:0]      d_reg;

    logic                       v3_reg;
    cls_t                       cls_reg;
    cls_t                       cls_next;
    logic [XW-1:0]              sqx_reg;
    logic [XW-1:0]              sqx_next;
    logic [YW-1:0]              sqy_reg;
    logic [YW-1:0]              sqy_next;
    logic [DSW-1:0]             dmag;
    logic                       dz;
    logic signed [NW-1:0]       neg_b;
    logic signed [DW-1:0]       two_a;

    logic [SLAT-1:0]            vs_reg;
    cls_t                       side_reg [SLAT];
    logic [RW-1:0]              sq_root;

    logic                       v4_reg;
    logic signed [NW-1:0]       n1_reg;
    logic signed [NW-1:0]       n2_reg;
    logic signed [DW-1:0]       den1_reg;
    logic signed [DW-1:0]       den2_reg;
    tail_t                      tail4_reg;

    logic [DLAT-1:0]            vd_reg;
    tail_t                      tail_reg [DLAT];
    qrs_pkg::div_res_t          div1_res;
    qrs_pkg::div_res_t          div2_res;

    tail_t                      tail;
    satv_t                      lane1;
    satv_t                      lane2;
    logic                       root_big;
    logic                       root_over;
    logic                       m_valid_reg;
    qrs_pkg::roots_t            m_data_reg;
    qrs_pkg::roots_t            m_data_next;

    // Whole pipeline advances unless the result beat is held
    assign pipe_en   = !m_valid_reg || m_ready;
    assign s_ready   = !skid_full_reg;
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TB'(1);
        end else if (cfg_valid && cfg_ready) begin
            tol_reg <= cfg_data;
        end
    end

    // Entry stage with one skid slot for a beat taken during a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
            v0_reg        <= 1'b0;
        end else if (pipe_en) begin
            v0_reg        <= skid_full_reg || s_acc;
            skid_full_reg <= 1'b0;
        end else if (s_acc) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in0_reg <= skid_full_reg ? skid_reg : s_data;
        end else if (s_acc) begin
            skid_reg <= s_data;
        end
    end

    // Stage 1: products and zero tests
    always_comb begin
        st1_next.a    = in0_reg.coeff_a;
        st1_next.b    = in0_reg.coeff_b;
        st1_next.c    = in0_reg.coeff_c;
        st1_next.cv   = in0_reg.coeffs_valid;
        st1_next.amag = mag(in0_reg.coeff_a);
        st1_next.cmag = mag(in0_reg.coeff_c);
        st1_next.za   = mag(in0_reg.coeff_a) < W'(tol_reg);
        st1_next.zb   = mag(in0_reg.coeff_b) < W'(tol_reg);
        st1_next.zc   = mag(in0_reg.coeff_c) < W'(tol_reg);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st1_reg <= st1_next;
            bb_reg  <= in0_reg.coeff_b * in0_reg.coeff_b;
            ac_reg  <= in0_reg.coeff_a * in0_reg.coeff_c;
        end
    end

    // Stage 2: discriminant b*b - 4*a*c
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st2_reg <= st1_reg;
            d_reg   <= DSW'(bb_reg) - (DSW'(ac_reg) <<< 2);
        end
    end

    // Stage 3: pick the solution path
    always_comb begin
        dmag  = d_reg[DSW-1] ? -d_reg : d_reg;
        dz    = dmag < DSW'({tol_reg, {FB{1'b0}}});
        neg_b = -NW'(st2_reg.b);
        two_a = DW'(st2_reg.a) <<< 1;

        cls_next.op    = qrs_pkg::OP_CONST;
        cls_next.kind  = qrs_pkg::KIND_NONE;
        cls_next.n1b   = '0;
        cls_next.n2b   = '0;
        cls_next.add_s = 1'b0;
        cls_next.sub_s = 1'b0;
        cls_next.den1  = '0;
        cls_next.den2  = '0;
        sqx_next       = '0;
        sqy_next       = '0;

        if (!st2_reg.cv) begin
            cls_next.kind = qrs_pkg::KIND_ERROR;
        end else if (st2_reg.za) begin
            // linear case
            if (st2_reg.zb && st2_reg.zc) begin
                cls_next.kind = qrs_pkg::KIND_ANY;
            end else if (!st2_reg.zb) begin
                cls_next.op   = qrs_pkg::OP_R1;
                cls_next.kind = qrs_pkg::KIND_ONE;
                cls_next.n1b  = -NW'(st2_reg.c);
                cls_next.den1 = DW'(st2_reg.b);
            end
        end else if (dz && !st2_reg.zb && !st2_reg.zc) begin
            cls_next.op   = qrs_pkg::OP_R1;
            cls_next.kind = qrs_pkg::KIND_ONE;
            cls_next.n1b  = neg_b;
            cls_next.den1 = two_a;
        end else if (d_reg[DSW-1]) begin
            cls_next.kind = qrs_pkg::KIND_NONE;
        end else if (st2_reg.zb) begin
            // x^2 = -c/a
            if (st2_reg.c == '0) begin
                cls_next.kind = qrs_pkg::KIND_ONE;
            end else if (st2_reg.c[W-1] ^ st2_reg.a[W-1]) begin
                cls_next.op   = qrs_pkg::OP_SQRT;
                cls_next.kind = qrs_pkg::KIND_TWO;
                sqx_next      = XW'(st2_reg.cmag) << (2 * FB);
                sqy_next      = st2_reg.amag;
            end
        end else if (st2_reg.zc) begin
            cls_next.op   = qrs_pkg::OP_R2;
            cls_next.kind = qrs_pkg::KIND_TWO;
            cls_next.n2b  = neg_b;
            cls_next.den2 = DW'(st2_reg.a);
        end else if (d_reg != '0) begin
            cls_next.op    = qrs_pkg::OP_BOTH;
            cls_next.kind  = qrs_pkg::KIND_TWO;
            cls_next.n1b   = neg_b;
            cls_next.n2b   = neg_b;
            cls_next.add_s = 1'b1;
            cls_next.sub_s = 1'b1;
            cls_next.den1  = two_a;
            cls_next.den2  = two_a;
            sqx_next       = d_reg[XW-1:0];
            sqy_next       = YW'(1);
        end else begin
            cls_next.op   = qrs_pkg::OP_R1;
            cls_next.kind = qrs_pkg::KIND_ONE;
            cls_next.n1b  = neg_b;
            cls_next.den1 = two_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cls_reg <= cls_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
    end

    // Square root, sideband delayed alongside
    qrs_sqrt u_sqrt (
        .aclk (aclk),
        .en   (pipe_en),
        .x    (sqx_reg),
        .y    (sqy_reg),
        .root (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= cls_reg;
            for (int k = 1; k < SLAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Stage 4: numerators -b +/- s
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n1_reg <= side_reg[SLAT-1].n1b
                      + (side_reg[SLAT-1].add_s ? $signed(NW'(sq_root)) : NW'(0));
            n2_reg <= side_reg[SLAT-1].n2b
                      - (side_reg[SLAT-1].sub_s ? $signed(NW'(sq_root)) : NW'(0));
            den1_reg       <= side_reg[SLAT-1].den1;
            den2_reg       <= side_reg[SLAT-1].den2;
            tail4_reg.op   <= side_reg[SLAT-1].op;
            tail4_reg.kind <= side_reg[SLAT-1].kind;
            tail4_reg.root <= sq_root;
        end
    end

    // Two divider lanes, one per root
    qrs_div u_div1 (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (n1_reg),
        .den  (den1_reg),
        .res  (div1_res)
    );

    qrs_div u_div2 (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (n2_reg),
        .den  (den2_reg),
        .res  (div2_res)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            tail_reg[0] <= tail4_reg;
            for (int k = 1; k < DLAT; k++) begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            vs_reg      <= '0;
            v4_reg      <= 1'b0;
            vd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            vs_reg      <= {vs_reg[SLAT-2:0], v3_reg};
            v4_reg      <= vs_reg[SLAT-1];
            vd_reg      <= {vd_reg[DLAT-2:0], v4_reg};
            m_valid_reg <= vd_reg[DLAT-1];
        end
    end

    // Output stage: saturate and assemble the result beat
    always_comb begin
        tail      = tail_reg[DLAT-1];
        lane1     = sat_div(div1_res);
        lane2     = sat_div(div2_res);
        root_big  = |tail.root[RW-1:W-1];
        root_over = tail.root[RW-1] || (tail.root[W-1] && (|tail.root[W-2:0]));

        m_data_next.root_kind = tail.kind;
        m_data_next.root_one  = '0;
        m_data_next.root_two  = '0;
        m_data_next.saturated = 1'b0;

        unique case (tail.op)
            qrs_pkg::OP_R1: begin
                m_data_next.root_one  = lane1.val;
                m_data_next.saturated = lane1.clip;
            end
            qrs_pkg::OP_R2: begin
                m_data_next.root_two  = lane2.val;
                m_data_next.saturated = lane2.clip;
            end
            qrs_pkg::OP_BOTH: begin
                m_data_next.root_one  = lane1.val;
                m_data_next.root_two  = lane2.val;
                m_data_next.saturated = lane1.clip || lane2.clip;
            end
            qrs_pkg::OP_SQRT: begin
                m_data_next.root_one  = root_big ? qrs_pkg::WMAX : $signed(tail.root[W-1:0]);
                m_data_next.root_two  = root_over ? qrs_pkg::WMIN
                                                  : -$signed(tail.root[W-1:0]);
                m_data_next.saturated = root_big;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.root_kind == qrs_pkg::KIND_ERROR) |->
        (m_data.root_one == '0 && m_data.root_two == '0 && !m_data.saturated))
        else $error("error beat carries nonzero roots");

    a_rootless_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.root_kind == qrs_pkg::KIND_NONE ||
                     m_data.root_kind == qrs_pkg::KIND_ANY)) |->
        (m_data.root_one == '0 && m_data.root_two == '0 && !m_data.saturated))
        else $error("rootless beat carries root data");

    a_one_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.root_kind == qrs_pkg::KIND_ONE) |-> (m_data.root_two == '0))
        else $error("single root beat has second root set");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !pipe_en) |=> !s_ready)
        else $error("beat taken during stall not held in skid slot");
`endif

endmodule
